// ===== rtl/morse_key_timing_decoder_assert.svh =====
// Assertion macros for the Morse key timing decoder.
`ifndef MORSE_KEY_TIMING_DECODER_ASSERT_SVH
`define MORSE_KEY_TIMING_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Expression holds at every edge outside reset.
`define MKTD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mktd assertion failed");

// Antecedent implies consequent in the same cycle.
`define MKTD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mktd assertion failed");

// Antecedent implies consequent in the next cycle.
`define MKTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mktd assertion failed");

`else

`define MKTD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define MKTD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define MKTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mktd_pkg.sv =====
// Shared types, constants and the code table of the Morse key timing decoder.
package mktd_pkg;

  localparam int DEFAULT_MAX_SYMBOLS  = 5;
  localparam int DEFAULT_COUNTER_BITS = 16;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 16;

  // Register indexes
  localparam int REG_DOT_MIN    = 0;
  localparam int REG_DOT_MAX    = 1;
  localparam int REG_DASH_MIN   = 2;
  localparam int REG_DASH_MAX   = 3;
  localparam int REG_LETTER_MIN = 4;
  localparam int REG_LETTER_MAX = 5;
  localparam int REG_WORD_MIN   = 6;
  localparam int REG_WORD_MAX   = 7;

  localparam logic [CFG_W-1:0] REG_RESET [REG_COUNT] = '{
    16'd150, 16'd350, 16'd650, 16'd850, 16'd700, 16'd800, 16'd950, 16'd1050
  };

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;

  // Code table: symbol k at bit k, 1 = dash. Letters A..Z then 1..9, 0.
  localparam int TABLE_SIZE   = 36;
  localparam int CODE_MAX_LEN = 5;

  localparam logic [2:0] CODE_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] CODE_BITS [TABLE_SIZE] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,
    5'd14, 5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,
    5'd0,  5'd1,  5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
    5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15, 5'd31
  };

  localparam logic [CHAR_W-1:0] CODE_CHAR [TABLE_SIZE] = '{
    7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73,
    7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
    7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90,
    7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd48
  };

  // Window register set
  typedef struct packed {
    logic [CFG_W-1:0] dot_min;
    logic [CFG_W-1:0] dot_max;
    logic [CFG_W-1:0] dash_min;
    logic [CFG_W-1:0] dash_max;
    logic [CFG_W-1:0] letter_min;
    logic [CFG_W-1:0] letter_max;
    logic [CFG_W-1:0] word_min;
    logic [CFG_W-1:0] word_max;
  } mktd_cfg_t;

  // Results of one tick, letter first then space
  typedef struct packed {
    logic              letter_valid;
    logic [CHAR_W-1:0] letter;
    logic              space_valid;
  } mktd_push_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_of_run;
  } mktd_entry_t;

  // Returns the ASCII code for a code, zero when no entry matches.
  function automatic logic [CHAR_W-1:0] code_lookup(logic [2:0] len, logic [4:0] bits);
    logic [CHAR_W-1:0] c;
    c = '0;
    for (int e = 0; e < TABLE_SIZE; e++) begin
      if (CODE_LEN[e] == len && CODE_BITS[e] == bits) c = CODE_CHAR[e];
    end
    return c;
  endfunction

endpackage

// ===== rtl/mktd_core.sv =====
// Edge timing, symbol assembly and code lookup of the Morse key timing decoder.
module mktd_core import mktd_pkg::*; #(
  parameter int MAX_SYMBOLS  = DEFAULT_MAX_SYMBOLS,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       key,
  input  mktd_cfg_t  cfg,
  output mktd_push_t push
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

  logic                    prev_level;
  logic [COUNTER_BITS-1:0] ticks;
  logic [MAX_SYMBOLS-1:0]  symbol_bits;
  logic [CNT_W-1:0]        symbol_count;
  logic                    code_overflow;

  logic                    prev_level_next;
  logic [COUNTER_BITS-1:0] ticks_next;
  logic [MAX_SYMBOLS-1:0]  symbol_bits_next;
  logic [CNT_W-1:0]        symbol_count_next;
  logic                    code_overflow_next;

  logic [COUNTER_BITS-1:0] dur;
  logic [CMP_W-1:0]        dur_x;
  logic rising, falling, letter_win, word_win, dot_win, dash_win, lookup_ok;
  logic [CHAR_W-1:0]       found;

  // Exclusive window test
  function automatic logic in_win(logic [CMP_W-1:0] d, logic [CFG_W-1:0] lo,
                                  logic [CFG_W-1:0] hi);
    return (d > CMP_W'(lo)) && (d < CMP_W'(hi));
  endfunction

  // Saturating advance; on an edge this is the length of the level that ended
  assign dur   = (ticks == '1) ? ticks : ticks + COUNTER_BITS'(1);
  assign dur_x = CMP_W'(dur);

  assign rising  = key && !prev_level;
  assign falling = !key && prev_level;

  assign letter_win = in_win(dur_x, cfg.letter_min, cfg.letter_max);
  assign word_win   = !letter_win && in_win(dur_x, cfg.word_min, cfg.word_max);
  assign dot_win    = in_win(dur_x, cfg.dot_min, cfg.dot_max);
  assign dash_win   = !dot_win && in_win(dur_x, cfg.dash_min, cfg.dash_max);

  assign lookup_ok = !code_overflow && (symbol_count != '0) &&
                     (symbol_count <= CNT_W'(CODE_MAX_LEN));
  assign found     = lookup_ok ? code_lookup(symbol_count[2:0], symbol_bits[4:0]) : '0;

  assign push.letter_valid = go && rising && (letter_win || word_win) && (found != '0);
  assign push.letter       = found;
  assign push.space_valid  = go && rising && word_win;

  always_comb begin
    prev_level_next    = key;
    ticks_next         = (rising || falling) ? '0 : dur;
    symbol_bits_next   = symbol_bits;
    symbol_count_next  = symbol_count;
    code_overflow_next = code_overflow;
    if (rising && (letter_win || word_win)) begin
      symbol_bits_next   = '0;
      symbol_count_next  = '0;
      code_overflow_next = 1'b0;
    end else if (falling && (dot_win || dash_win)) begin
      if (symbol_count >= CNT_W'(MAX_SYMBOLS)) begin
        code_overflow_next = 1'b1;
      end else begin
        symbol_bits_next[symbol_count[IDX_W-1:0]] = dash_win;
        symbol_count_next = symbol_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level    <= 1'b0;
      ticks         <= '0;
      symbol_bits   <= '0;
      symbol_count  <= '0;
      code_overflow <= 1'b0;
    end else if (go) begin
      prev_level    <= prev_level_next;
      ticks         <= ticks_next;
      symbol_bits   <= symbol_bits_next;
      symbol_count  <= symbol_count_next;
      code_overflow <= code_overflow_next;
    end
  end

endmodule

// ===== rtl/mktd_out_fifo.sv =====
// Result queue of the Morse key timing decoder, two words in, one word out.
module mktd_out_fifo import mktd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mktd_push_t         push,
  output logic [LEVEL_W-1:0] level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last_of_run
);

  mktd_entry_t      mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] space_ptr;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = {1'b0, push.letter_valid} + {1'b0, push.space_valid};
  assign space_ptr = push.letter_valid ? wr_ptr + PTR_W'(1) : wr_ptr;

  assign out_valid   = (level != '0);
  assign pop         = out_valid && !out_stall;
  assign char_code   = mem[rd_ptr].char_code;
  assign last_of_run = mem[rd_ptr].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level + LEVEL_W'(n_push) - LEVEL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.letter_valid) begin
      mem[wr_ptr] <= '{char_code: push.letter, last_of_run: !push.space_valid};
    end
    if (push.space_valid) begin
      mem[space_ptr] <= '{char_code: SPACE_CHAR, last_of_run: 1'b1};
    end
  end

endmodule

// ===== rtl/morse_key_timing_decoder.sv =====
// Top level of the Morse key timing decoder: config registers, input stage, core, queue.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   in       | in_valid / in_stall    | key_level (one ms tick)
//   out      | out_valid / out_stall  | char_code, last_of_run
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (16 bits)
//
// One tick is taken per cycle while there is room, held in the input register;
// the core updates its state and pushes up to two words into a four-word queue.
// A tick waits in the input register while the queue has fewer than two free
// words, so out_stall backs up into in_stall; nothing else slows the block.
// Reset (synchronous) loads the default windows and clears timing and code state.
// cfg_ready is always high; indexes beyond the last register are dropped.
module morse_key_timing_decoder import mktd_pkg::*; #(
  parameter int MAX_SYMBOLS  = DEFAULT_MAX_SYMBOLS,
  parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 key_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    char_code,
  output logic                 last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "morse_key_timing_decoder_assert.svh"

  logic [CFG_W-1:0]   cfg_regs [REG_COUNT];
  mktd_cfg_t          cfg;

  // Input register
  logic               in_q_valid;
  logic               key_q;
  logic               room;
  logic               go;
  logic               in_take;

  mktd_push_t         push;
  logic [LEVEL_W-1:0] fifo_level;

  // Config writes land directly; the user must issue them while idle, unchecked here
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= REG_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
      cfg_regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign cfg = '{
    dot_min:    cfg_regs[REG_DOT_MIN],
    dot_max:    cfg_regs[REG_DOT_MAX],
    dash_min:   cfg_regs[REG_DASH_MIN],
    dash_max:   cfg_regs[REG_DASH_MAX],
    letter_min: cfg_regs[REG_LETTER_MIN],
    letter_max: cfg_regs[REG_LETTER_MAX],
    word_min:   cfg_regs[REG_WORD_MIN],
    word_max:   cfg_regs[REG_WORD_MAX]
  };

  // A held tick moves on only when the queue can take both possible words
  assign room     = (fifo_level <= LEVEL_W'(FIFO_DEPTH - 2));
  assign go       = in_q_valid && room;
  assign in_stall = in_q_valid && !room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (go) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_q <= key_level;
    end
  end

  mktd_core #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .key  (key_q),
    .cfg  (cfg),
    .push (push)
  );

  mktd_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .level       (fifo_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last_of_run (last_of_run)
  );

  // Words only come from a tick that presses the key
  `MKTD_ASSERT_IMPLIES(a_push_on_press, clk, rst, push.letter_valid || push.space_valid, go && key_q)
  // Queue never overfills
  `MKTD_ASSERT_ALWAYS(a_fifo_bound, clk, rst, fifo_level <= LEVEL_W'(FIFO_DEPTH))
  // A taken tick is held in the input register next cycle
  `MKTD_ASSERT_NEXT(a_tick_held, clk, rst, in_take, in_q_valid)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Morse key timing decoder.
module tb;
  import mktd_pkg::*;

  // Build of the decoder under test
  localparam int SYMBOL_LIMIT = 5;
  localparam int COUNT_W      = 16;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_PCT     = 9;     // chance per cycle that a side idles
  localparam int LONG_HOLD    = 300;   // one long receiver hold-off, in cycles
  // A tick is held in the input register, then the core pushes at most two words
  // into a four-word queue; the drain gives a tick with no output time to pass.
  localparam int DRAIN_CYCLES = 12;
  // About 1550 ticks in all. A correct run is lengthened by 9% sender gaps, a
  // receiver that may owe two words per tick, the long hold-off and the drains.
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int REPORT_LIMIT = 10;

  // Register indexes past the last window register; the block must drop them
  localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = CFG_IDX_W'(REG_COUNT);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

  localparam logic [COUNT_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } decoded_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 key_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    char_code;
  logic                 last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  morse_key_timing_decoder #(
    .MAX_SYMBOLS (SYMBOL_LIMIT),
    .COUNTER_BITS(COUNT_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_level  (key_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the windows and of the timing and code state
  // ---------------------------------------------------------------------------
  // Symbol k of a code is character k of the string; letters A..Z then 1..9, 0.
  string morse_codes [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
    ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.", "-----"
  };
  string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

  logic [CFG_W-1:0]        win [REG_COUNT];  // window bounds, exclusive
  logic                    prev_key;
  logic [COUNT_W-1:0]      run_ticks;        // saturating ticks since last edge
  logic [SYMBOL_LIMIT-1:0] code_bits;        // 1 = dash
  int                      code_len;
  logic                    code_overflow;

  decoded_t pending_chars [$];   // words still owed by the block, oldest first
  logic     key_plan [$];        // key samples not yet offered
  int       mismatches = 0;
  int       cycles = 0;
  logic     calm = 1'b0;         // no idling on either side while set
  logic     long_hold_start = 1'b0;

  function automatic logic in_window(logic [COUNT_W-1:0] d, int lo_idx);
    return d > win[lo_idx] && d < win[lo_idx + 1];
  endfunction

  // ASCII of the held code, zero when it is empty, overflowed or unknown
  function automatic logic [CHAR_W-1:0] held_char();
    string                   s;
    logic [SYMBOL_LIMIT-1:0] b;
    byte                     g;
    if (code_overflow || code_len == 0) return '0;
    for (int e = 0; e < 36; e++) begin
      s = morse_codes[e];
      b = '0;
      for (int k = 0; k < s.len(); k++) if (s[k] == "-") b[k] = 1'b1;
      if (s.len() == code_len && b == code_bits) begin
        g = glyphs[e];
        return g[CHAR_W-1:0];
      end
    end
    return '0;
  endfunction

  function automatic void add_symbol(logic dash);
    if (code_len >= SYMBOL_LIMIT) begin
      code_overflow = 1'b1;
    end else begin
      code_bits[code_len] = dash;
      code_len++;
    end
  endfunction

  // One accepted key sample: advance the model, queue the words it causes
  function automatic void decode_tick(logic level);
    decoded_t          run [2];
    int                n;
    logic [CHAR_W-1:0] c;
    logic              letter;
    logic              word;
    n = 0;
    if (run_ticks != TICK_MAX) run_ticks++;
    if (level && !prev_key) begin
      // key pressed: the gap that just ended may close a letter or a word
      letter = in_window(run_ticks, REG_LETTER_MIN);
      word = !letter && in_window(run_ticks, REG_WORD_MIN);
      if (letter || word) begin
        c = held_char();
        if (c != '0) begin
          run[n] = '{ch: c, last: 1'b0};
          n++;
        end
        if (word) begin
          run[n] = '{ch: SPACE_CHAR, last: 1'b0};
          n++;
        end
        code_bits = '0;
        code_len = 0;
        code_overflow = 1'b0;
      end
      run_ticks = '0;
    end else if (!level && prev_key) begin
      // key released: dot window checked first
      if (in_window(run_ticks, REG_DOT_MIN)) add_symbol(1'b0);
      else if (in_window(run_ticks, REG_DASH_MIN)) add_symbol(1'b1);
      run_ticks = '0;
    end
    prev_key = level;
    if (n > 0) run[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_chars.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void hold_key(logic level, int n);
    repeat (n) key_plan.push_back(level);
  endfunction

  // Keys a code: each symbol is a press followed by a release gap
  function automatic void send_code(string s, int dot_t, int dash_t, int space_t, int end_gap);
    for (int k = 0; k < s.len(); k++) begin
      hold_key(1'b1, (s[k] == "-") ? dash_t : dot_t);
      hold_key(1'b0, (k + 1 == s.len()) ? end_gap : space_t);
    end
  endfunction

  // A duration strictly inside a window if one fits, kept near its lower bound
  function automatic int pick_inside(int lo, int hi);
    if (hi - lo < 2) return lo + 1;
    return $urandom_range(lo + 1, (hi - 1 < lo + 5) ? hi - 1 : lo + 5);
  endfunction

  function automatic int window_pick(int lo_idx);
    return pick_inside(win[lo_idx], win[lo_idx + 1]);
  endfunction

  // Mostly well-formed letters with jittered timing; some unknown or overlong
  // codes, some mistimed presses and gaps, and plain noise runs in between.
  function automatic void random_keying(int n_ticks);
    int    target;
    int    roll;
    int    sym_len;
    int    down;
    int    gap;
    int    cap;
    string s;
    target = key_plan.size() + n_ticks;
    while (key_plan.size() < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if (roll < 8) begin
          s = "";
          sym_len = $urandom_range(1, 7);
          for (int k = 0; k < sym_len; k++) begin
            if ($urandom_range(0, 1) == 1) s = {s, "-"};
            else s = {s, "."};
          end
        end else begin
          s = morse_codes[$urandom_range(0, 35)];
        end
        for (int k = 0; k < s.len(); k++) begin
          down = (s[k] == "-") ? window_pick(REG_DASH_MIN) : window_pick(REG_DOT_MIN);
          if ($urandom_range(0, 19) == 0) down = $urandom_range(1, 12);
          if (k + 1 < s.len()) begin
            // gap between symbols stays at or below the letter window
            cap = (win[REG_LETTER_MIN] < 6) ? int'(win[REG_LETTER_MIN]) : 6;
            gap = (cap < 1) ? 1 : $urandom_range(1, cap);
          end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) gap = window_pick(REG_LETTER_MIN);
            else if (roll < 85) gap = window_pick(REG_WORD_MIN);
            else gap = $urandom_range(1, 16);
          end
          hold_key(1'b1, down);
          hold_key(1'b0, gap);
        end
      end else begin
        hold_key(1'($urandom_range(0, 1)), $urandom_range(1, 10));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes, only while the block is idle
  // ---------------------------------------------------------------------------
  // Called just after the clock rises. Leaves cfg_valid high so that a following
  // write keeps it up; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_COUNT) win[idx] = val;
  endtask

  task automatic set_windows(int dot_lo, int dot_hi, int dash_lo, int dash_hi,
                             int let_lo, int let_hi, int word_lo, int word_hi);
    write_reg(CFG_IDX_W'(REG_DOT_MIN), CFG_W'(dot_lo));
    write_reg(CFG_IDX_W'(REG_DOT_MAX), CFG_W'(dot_hi));
    write_reg(CFG_IDX_W'(REG_DASH_MIN), CFG_W'(dash_lo));
    write_reg(CFG_IDX_W'(REG_DASH_MAX), CFG_W'(dash_hi));
    write_reg(CFG_IDX_W'(REG_LETTER_MIN), CFG_W'(let_lo));
    write_reg(CFG_IDX_W'(REG_LETTER_MAX), CFG_W'(let_hi));
    write_reg(CFG_IDX_W'(REG_WORD_MIN), CFG_W'(word_lo));
    write_reg(CFG_IDX_W'(REG_WORD_MAX), CFG_W'(word_hi));
  endtask

  // Wait until every sample is taken and every owed word has come out, give a
  // tick without output time to pass through, then check again for a sample
  // that was offered on the very edge the first wait ended.
  task automatic settle();
    while (key_plan.size() != 0 || in_valid || pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_valid || pending_chars.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers key samples from key_plan, feeds the model on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_tick(key_level);
      // a stalled sample stays put; otherwise offer the next one or idle
      if (!in_valid || !in_stall) begin
        if (key_plan.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          key_level <= key_plan.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted word against the oldest owed one and
  // drives out_stall, including one long hold-off on request
  // ---------------------------------------------------------------------------
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  decoded_t want;

  task automatic note_mismatch(string what, int exp_val, int got_val);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          note_mismatch("char_code with no word owed", -1, char_code);
        end else begin
          want = pending_chars.pop_front();
          if (char_code !== want.ch) note_mismatch("char_code", want.ch, char_code);
          if (last_of_run !== want.last) note_mismatch("last_of_run", want.last, last_of_run);
        end
      end
      if (long_hold_start && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // model comes out of reset with the default windows
    win[REG_DOT_MIN]    = 16'd150;
    win[REG_DOT_MAX]    = 16'd350;
    win[REG_DASH_MIN]   = 16'd650;
    win[REG_DASH_MAX]   = 16'd850;
    win[REG_LETTER_MIN] = 16'd700;
    win[REG_LETTER_MAX] = 16'd800;
    win[REG_WORD_MIN]   = 16'd950;
    win[REG_WORD_MAX]   = 16'd1050;
    prev_key      = 1'b0;
    run_ticks     = '0;
    code_bits     = '0;
    code_len      = 0;
    code_overflow = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset windows: a real-time E closed by a letter gap
    send_code(".", 160, 0, 0, 710);
    hold_key(1'b1, 4);
    hold_key(1'b0, 2);
    settle();

    // Fast windows: dot 2..3, dash 5..7, letter gap 6..8, word gap 10..13
    set_windows(1, 4, 4, 8, 5, 9, 9, 14);
    cfg_valid <= 1'b0;
    send_code(".", 3, 6, 2, 7);           // E on a letter gap
    send_code("-----", 3, 6, 2, 12);      // 0, then space
    send_code(".-", 2, 7, 2, 8);          // A with durations on the inner edges
    // press of 4 sits on both dot max and dash min, 8 on dash max: dropped,
    // code in progress survives them
    hold_key(1'b1, 3); hold_key(1'b0, 2);
    hold_key(1'b1, 4); hold_key(1'b0, 2);
    hold_key(1'b1, 8); hold_key(1'b0, 2);
    hold_key(1'b1, 6); hold_key(1'b0, 7);  // .- -> A
    send_code("......", 3, 6, 2, 7);      // overflow: nothing
    send_code("-", 3, 6, 2, 7);           // T after the overflow clears
    send_code("..--", 3, 6, 2, 12);       // unknown code: space only
    hold_key(1'b1, 20); hold_key(1'b0, 12); // empty code at a word gap: space
    // gaps on the excluded bounds end nothing; code grows to ...-
    send_code(".", 3, 6, 2, 5);
    hold_key(1'b1, 3); hold_key(1'b0, 9);
    hold_key(1'b1, 3); hold_key(1'b0, 14);
    hold_key(1'b1, 6); hold_key(1'b0, 6); // V
    send_code("....-", 3, 6, 2, 13);      // 4, then space
    hold_key(1'b1, 2); hold_key(1'b0, 1);
    random_keying(100);
    settle();

    // Overlapping windows: dot wins 4..5, letter gap wins 9..10.
    // Whole phase runs with no idling on either side.
    set_windows(1, 6, 3, 8, 5, 11, 8, 14);
    cfg_valid <= 1'b0;
    calm <= 1'b1;
    hold_key(1'b1, 4); hold_key(1'b0, 3);
    hold_key(1'b1, 6); hold_key(1'b0, 9);  // A, no space
    hold_key(1'b1, 2); hold_key(1'b0, 2);
    random_keying(60);
    settle();
    calm <= 1'b0;

    // Empty windows: nothing can ever match
    set_windows(0, 0, 0, 0, 0, 0, 0, 0);
    cfg_valid <= 1'b0;
    random_keying(30);
    settle();

    // Widest windows: every press is a dot, every gap ends a letter, so the
    // output is dense. Writes past the last register must be dropped. The
    // receiver holds off for a long stretch while samples keep coming.
    set_windows(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF);
    write_reg(IDX_PAST_END, 16'hFFFF);
    write_reg(IDX_TOP, 16'h0001);
    cfg_valid <= 1'b0;
    long_hold_start <= 1'b1;
    random_keying(100);
    settle();

    // Back to fast windows for a last random stretch
    set_windows(1, 4, 4, 8, 5, 9, 9, 14);
    cfg_valid <= 1'b0;
    random_keying(40);
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== morse_key_timing_decoder.f =====
+incdir+rtl
rtl/mktd_pkg.sv
rtl/mktd_core.sv
rtl/mktd_out_fifo.sv
rtl/morse_key_timing_decoder.sv
tb/sv/tb.sv
